// ===== rtl/swoi_pkg.sv =====
// Constants, tables and helpers shared by the steered wheel odometry integrator.
package swoi_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam logic [4:0] CORDIC_LAST = 5'd29;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
	localparam logic [31:0] RAD_TO_BAM = 32'd1367130551;
	localparam logic [31:0] YAW_TO_BAM = 32'd44798134;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [2:0] REG_DRIVE_DISTANCE = 3'd0;
	localparam logic [2:0] REG_DRIVE_SPEED = 3'd1;
	localparam logic [2:0] REG_STEER_ANGLE = 3'd2;
	localparam logic [2:0] REG_TOOL_POSITION = 3'd3;
	localparam logic [2:0] REG_INV_HALF_WB = 3'd4;

	localparam logic signed [31:0] RST_DRIVE_DISTANCE = 32'sd3564288;
	localparam logic signed [31:0] RST_DRIVE_SPEED = 32'sd3564288;
	localparam logic signed [31:0] RST_STEER_ANGLE = 32'sd426160;
	localparam logic signed [31:0] RST_TOOL_POSITION = -32'sd28644;
	localparam logic [23:0] RST_INV_HALF_WB = 24'd236169;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/steered_wheel_odometry_integrator_core.sv =====
// Steered wheel odometry integrator: sequenced multiplier and CORDIC datapath.
//
// Usage: one telemetry sample is a transfer on the input channel (in_valid /
// in_ready); one pose result is a transfer on the output channel (out_valid /
// out_ready). Gains are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// Each sample runs through a sequencer around one 32x32 unsigned multiplier
// (ten scaled products, each in set, low-half, high-half and finish steps, plus
// the heading step) and one shift-add CORDIC (three runs). in_ready stays low
// until the result is loaded: no new sample is taken before the last is done.
// The result sits in an output register: the next sample may be taken while it
// waits; a finished sample then holds in the last step until out_ready.
// Reset clears pose, heading and the time stamp, loads the default gains and
// marks no sample seen, so the first sample integrates with a zero interval.
module steered_wheel_odometry_integrator_core #(
	parameter int COUNT_WIDTH = 32,
	parameter int POSITION_WIDTH = 48,
	parameter int TIME_WIDTH = 48
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [COUNT_WIDTH-1:0] front_drive_delta,
	input logic signed [COUNT_WIDTH-1:0] rear_drive_delta,
	input logic signed [COUNT_WIDTH-1:0] front_steer_count,
	input logic signed [COUNT_WIDTH-1:0] rear_steer_count,
	input logic signed [COUNT_WIDTH-1:0] front_drive_rate,
	input logic signed [COUNT_WIDTH-1:0] rear_drive_rate,
	input logic signed [COUNT_WIDTH-1:0] tool_count,
	input logic [TIME_WIDTH-1:0] sample_time_us,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] wheel_speed,
	output logic signed [31:0] steer_rad,
	output logic signed [31:0] tool_level,
	output logic signed [31:0] yaw_rate,
	output logic signed [POSITION_WIDTH-1:0] position_x,
	output logic signed [POSITION_WIDTH-1:0] position_y,
	output logic [31:0] heading_angle,
	output logic signed [31:0] orientation_z,
	output logic signed [31:0] orientation_w
);
	import swoi_pkg::*;

	localparam int TRAVEL_W = COUNT_WIDTH + 24;
	localparam logic signed [65:0] POS_MAX = (66'sd1 <<< (POSITION_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] POS_MIN = -POS_MAX - 66'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_MSET, S_MLO, S_MHI, S_MFIN, S_CSET, S_CRUN, S_CFIN,
		S_YB, S_YN, S_D0, S_D1, S_D2, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_TRAVEL, OP_SPEED, OP_STEER, OP_TOOL, OP_BAM,
		OP_T1, OP_YAW, OP_C1, OP_EX, OP_EY
	} op_t;

	typedef enum logic [1:0] {CS_STEER, CS_HEAD, CS_NEW} csel_t;

	state_t state_q;
	op_t op_q;
	csel_t csel_q;

	logic signed [31:0] g_dist_q, g_speed_q, g_steer_q, g_tool_q;
	logic [23:0] ihw_q;

	logic signed [POSITION_WIDTH-1:0] pose_x_q, pose_y_q;
	logic [31:0] heading_q;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic time_valid_q;

	logic signed [COUNT_WIDTH:0] dd_q, dv_q, ds_q;
	logic signed [COUNT_WIDTH-1:0] tc_q;
	logic [63:0] dt_q;

	logic signed [TRAVEL_W-1:0] travel_q, c1_q;
	logic signed [31:0] speed_q, steer_q, tool_q, yaw_q;
	logic [31:0] bam_q;
	logic signed [32:0] t1_q;
	logic signed [31:0] sn_s_q, cs_s_q, sn_h_q, cs_h_q, nz_q, nw_q;

	logic [63:0] ma_q, pl_q, ph_q, aw_q;
	logic [31:0] mb_q;
	logic neg_q;

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0] i_q;
	logic flip_q;

	// operand selection
	logic signed [63:0] opa;
	logic signed [32:0] opb;
	logic [5:0] sh;

	always_comb begin
		opa = '0;
		opb = '0;
		sh = 6'd30;
		unique case (op_q)
			OP_TRAVEL: begin opa = 64'(dd_q); opb = 33'(g_dist_q); sh = 6'd9; end
			OP_SPEED: begin opa = 64'(dv_q); opb = 33'(g_speed_q); sh = 6'd17; end
			OP_STEER: begin opa = 64'(ds_q); opb = 33'(g_steer_q); sh = 6'd4; end
			OP_TOOL: begin opa = 64'(tc_q); opb = 33'(g_tool_q); sh = 6'd16; end
			OP_BAM: begin opa = 64'(steer_q); opb = {1'b0, RAD_TO_BAM}; sh = 6'd30; end
			OP_T1: begin opa = 64'(speed_q); opb = 33'(sn_s_q); sh = 6'd30; end
			OP_YAW: begin opa = 64'(t1_q); opb = {9'd0, ihw_q}; sh = 6'd16; end
			OP_C1: begin opa = 64'(travel_q); opb = 33'(cs_s_q); sh = 6'd30; end
			OP_EX: begin opa = 64'(c1_q); opb = 33'(cs_h_q); sh = 6'd30; end
			OP_EY: begin opa = 64'(c1_q); opb = 33'(sn_h_q); sh = 6'd30; end
		endcase
	end

	// shared multiplier
	logic [31:0] mul_a, mul_b, yaw_mag;
	logic [63:0] mul_p;

	assign yaw_mag = yaw_q[31] ? -yaw_q : yaw_q;

	always_comb begin
		unique case (state_q)
			S_MLO: begin mul_a = ma_q[31:0]; mul_b = mb_q; end
			S_MHI: begin mul_a = ma_q[63:32]; mul_b = mb_q; end
			S_YB: begin mul_a = yaw_mag; mul_b = YAW_TO_BAM; end
			S_D0: begin mul_a = aw_q[31:0]; mul_b = dt_q[31:0]; end
			S_D1: begin mul_a = aw_q[63:32]; mul_b = dt_q[31:0]; end
			S_D2: begin mul_a = aw_q[31:0]; mul_b = dt_q[63:32]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// rounding, saturation and sign of a scaled product
	logic [63:0] low, rsum, rmag;
	logic ovf;
	logic signed [63:0] mres;

	always_comb begin
		low = (pl_q >> sh) + 64'(pl_q[sh - 6'd1]);
		ovf = (ph_q >> (sh + 6'd31)) != 64'd0;
		rsum = (ph_q << (6'd32 - sh)) + low;
		rmag = (ovf || rsum[63]) ? MAG_MAX : rsum;
		mres = neg_q ? -signed'(rmag) : signed'(rmag);
	end

	logic signed [65:0] pos_sum;
	logic signed [POSITION_WIDTH-1:0] pos_sat;

	always_comb begin
		pos_sum = ((op_q == OP_EX) ? 66'(pose_x_q) : 66'(pose_y_q)) + 66'(mres);
		if (pos_sum > POS_MAX) begin
			pos_sat = POS_MAX[POSITION_WIDTH-1:0];
		end else if (pos_sum < POS_MIN) begin
			pos_sat = POS_MIN[POSITION_WIDTH-1:0];
		end else begin
			pos_sat = pos_sum[POSITION_WIDTH-1:0];
		end
	end

	// CORDIC setup, step and finish
	logic [31:0] ang, ang2;
	logic cflip;
	logic signed [33:0] xs, ys, at, xf, yf, xc, yc;

	always_comb begin
		unique case (csel_q)
			CS_STEER: ang = bam_q;
			CS_HEAD: ang = heading_q;
			default: ang = {1'b0, heading_q[31:1]};
		endcase
		cflip = ang[31] ^ ang[30];
		ang2 = cflip ? ang + HALF_TURN : ang;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = signed'({2'b00, atan_bam(i_q)});
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xc = (xf > ONE_Q30) ? ONE_Q30 : ((xf < -ONE_Q30) ? -ONE_Q30 : xf);
		yc = (yf > ONE_Q30) ? ONE_Q30 : ((yf < -ONE_Q30) ? -ONE_Q30 : yf);
	end

	logic [TIME_WIDTH-1:0] dt_raw;
	assign dt_raw = sample_time_us - last_time_q;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_TRAVEL;
			csel_q <= CS_STEER;
			g_dist_q <= RST_DRIVE_DISTANCE;
			g_speed_q <= RST_DRIVE_SPEED;
			g_steer_q <= RST_STEER_ANGLE;
			g_tool_q <= RST_TOOL_POSITION;
			ihw_q <= RST_INV_HALF_WB;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
			last_time_q <= '0;
			time_valid_q <= 1'b0;
			dd_q <= '0; dv_q <= '0; ds_q <= '0; tc_q <= '0; dt_q <= '0;
			travel_q <= '0; c1_q <= '0; t1_q <= '0;
			speed_q <= '0; steer_q <= '0; tool_q <= '0; yaw_q <= '0; bam_q <= '0;
			sn_s_q <= '0; cs_s_q <= '0; sn_h_q <= '0; cs_h_q <= '0;
			nz_q <= '0; nw_q <= '0;
			ma_q <= '0; mb_q <= '0; neg_q <= 1'b0;
			pl_q <= '0; ph_q <= '0; aw_q <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0; i_q <= '0; flip_q <= 1'b0;
			out_valid <= 1'b0;
			wheel_speed <= '0; steer_rad <= '0; tool_level <= '0; yaw_rate <= '0;
			position_x <= '0; position_y <= '0; heading_angle <= '0;
			orientation_z <= '0; orientation_w <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DRIVE_DISTANCE: g_dist_q <= cfg_data;
					REG_DRIVE_SPEED: g_speed_q <= cfg_data;
					REG_STEER_ANGLE: g_steer_q <= cfg_data;
					REG_TOOL_POSITION: g_tool_q <= cfg_data;
					REG_INV_HALF_WB: ihw_q <= cfg_data[23:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready && (state_q != S_OUT)) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dd_q <= (COUNT_WIDTH+1)'(rear_drive_delta)
							- (COUNT_WIDTH+1)'(front_drive_delta);
						dv_q <= (COUNT_WIDTH+1)'(rear_drive_rate)
							- (COUNT_WIDTH+1)'(front_drive_rate);
						ds_q <= (COUNT_WIDTH+1)'(front_steer_count)
							- (COUNT_WIDTH+1)'(rear_steer_count);
						tc_q <= tool_count;
						dt_q <= time_valid_q ? 64'(dt_raw) : 64'd0;
						last_time_q <= sample_time_us;
						time_valid_q <= 1'b1;
						op_q <= OP_TRAVEL;
						state_q <= S_MSET;
					end
				end
				S_MSET: begin
					ma_q <= opa[63] ? 64'(-opa) : 64'(opa);
					mb_q <= opb[32] ? 32'(-opb) : opb[31:0];
					neg_q <= opa[63] ^ opb[32];
					state_q <= S_MLO;
				end
				S_MLO: begin
					pl_q <= mul_p;
					state_q <= S_MHI;
				end
				S_MHI: begin
					ph_q <= mul_p;
					state_q <= S_MFIN;
				end
				S_MFIN: begin
					state_q <= S_MSET;
					unique case (op_q)
						OP_TRAVEL: begin travel_q <= mres[TRAVEL_W-1:0]; op_q <= OP_SPEED; end
						OP_SPEED: begin speed_q <= sat32(mres); op_q <= OP_STEER; end
						OP_STEER: begin steer_q <= sat32(mres); op_q <= OP_TOOL; end
						OP_TOOL: begin tool_q <= sat32(mres); op_q <= OP_BAM; end
						OP_BAM: begin
							bam_q <= mres[31:0];
							csel_q <= CS_STEER;
							state_q <= S_CSET;
						end
						OP_T1: begin t1_q <= mres[32:0]; op_q <= OP_YAW; end
						OP_YAW: begin
							yaw_q <= sat32(mres);
							csel_q <= CS_HEAD;
							state_q <= S_CSET;
						end
						OP_C1: begin c1_q <= mres[TRAVEL_W-1:0]; op_q <= OP_EX; end
						OP_EX: begin pose_x_q <= pos_sat; op_q <= OP_EY; end
						OP_EY: begin pose_y_q <= pos_sat; state_q <= S_YB; end
					endcase
				end
				S_CSET: begin
					x_q <= CORDIC_X0;
					y_q <= '0;
					z_q <= 34'(signed'(ang2));
					flip_q <= cflip;
					i_q <= '0;
					state_q <= S_CRUN;
				end
				S_CRUN: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					i_q <= i_q + 5'd1;
					if (i_q == CORDIC_LAST) begin
						state_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					unique case (csel_q)
						CS_STEER: begin
							sn_s_q <= yc[31:0];
							cs_s_q <= xc[31:0];
							op_q <= OP_T1;
							state_q <= S_MSET;
						end
						CS_HEAD: begin
							sn_h_q <= yc[31:0];
							cs_h_q <= xc[31:0];
							op_q <= OP_C1;
							state_q <= S_MSET;
						end
						default: begin
							nz_q <= yc[31:0];
							nw_q <= xc[31:0];
							state_q <= S_OUT;
						end
					endcase
				end
				S_YB: begin
					pl_q <= mul_p;
					state_q <= S_YN;
				end
				S_YN: begin
					aw_q <= yaw_q[31] ? -pl_q : pl_q;
					state_q <= S_D0;
				end
				S_D0: begin
					pl_q <= mul_p;
					state_q <= S_D1;
				end
				S_D1: begin
					ph_q <= mul_p;
					state_q <= S_D2;
				end
				S_D2: begin
					heading_q <= heading_q + pl_q[63:32] + ph_q[31:0] + mul_p[31:0];
					csel_q <= CS_NEW;
					state_q <= S_CSET;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						wheel_speed <= speed_q;
						steer_rad <= steer_q;
						tool_level <= tool_q;
						yaw_rate <= yaw_q;
						position_x <= pose_x_q;
						position_y <= pose_y_q;
						heading_angle <= heading_q;
						orientation_z <= nz_q;
						orientation_w <= nw_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	a_time_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> time_valid_q)
		else $error("sample seen flag not set after transfer");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && (!out_valid || out_ready) |=> out_valid && in_ready)
		else $error("finished sample not presented");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRUN) |-> (i_q < CORDIC_STEPS))
		else $error("CORDIC step count overrun");

endmodule
